// ----- hw/rtl/lbp_pkg.sv -----
package lbp_pkg;

  // Default field sizes
  parameter int unsigned VALUE_BITS     = 32;
  parameter int unsigned MAX_FIELD_BITS = 64;

  // Byte assembly
  parameter int unsigned BYTE_BITS = 8;
  parameter int unsigned HELD_BITS = BYTE_BITS - 1;
  parameter int unsigned HELD_CNT_BITS = $clog2(BYTE_BITS);

  // Depth of the queue between front and back
  parameter int unsigned QUEUE_DEPTH = 2;

  // Item commands
  typedef enum logic {
    CMD_APPEND  = 1'b0,
    CMD_DISCARD = 1'b1
  } cmd_e;

  // Handshake of the queue read side
  typedef struct packed {
    logic valid;
    logic ready;
  } pop_t;

endpackage

// ----- hw/rtl/lbp_if.sv -----
interface lbp_in_if #(
  parameter int unsigned ValueBits = lbp_pkg::VALUE_BITS,
  parameter int unsigned CountBits = $clog2(lbp_pkg::MAX_FIELD_BITS + 1)
);
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [ValueBits-1:0] value;
  logic                 is_signed;
  logic [CountBits-1:0] bit_count;

  modport source (output valid, cmd, value, is_signed, bit_count, input ready);
  modport sink   (input valid, cmd, value, is_signed, bit_count, output ready);
endinterface

interface lbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

// ----- hw/rtl/lbp_front.sv -----
module lbp_front #(
  parameter int unsigned ValueBits    = lbp_pkg::VALUE_BITS,
  parameter int unsigned MaxFieldBits = lbp_pkg::MAX_FIELD_BITS,
  localparam int unsigned CountBits   = $clog2(MaxFieldBits + 1),
  localparam int unsigned EntryBits   = ValueBits + CountBits + 2
) (
  lbp_in_if.sink                 in_i,
  output logic                   push_valid_o,
  output logic [EntryBits-1:0]   push_data_o,
  input  logic                   push_ready_i
);

  logic [CountBits-1:0] count_sat;
  logic                 fill;

  // Clamp the field width and resolve the sign fill bit
  always_comb begin
    if (in_i.bit_count > CountBits'(MaxFieldBits)) begin
      count_sat = CountBits'(MaxFieldBits);
    end else begin
      count_sat = in_i.bit_count;
    end
    fill = in_i.is_signed & in_i.value[ValueBits-1];
  end

  // Pass the classified word to the queue
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;
  assign push_data_o  = {in_i.cmd, fill, count_sat, in_i.value};

endmodule

// ----- hw/rtl/lbp_queue.sv -----
module lbp_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = lbp_pkg::QUEUE_DEPTH,
  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntBits = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output lbp_pkg::pop_t    pop_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = (cnt_q != CntBits'(Depth));
  assign pop_o.valid  = (cnt_q != '0);
  assign pop_o.ready  = pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_o.valid & pop_ready_i;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntBits'(push) - CntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/lbp_back.sv -----
module lbp_back #(
  parameter int unsigned ValueBits    = lbp_pkg::VALUE_BITS,
  parameter int unsigned MaxFieldBits = lbp_pkg::MAX_FIELD_BITS,
  localparam int unsigned CountBits   = $clog2(MaxFieldBits + 1),
  localparam int unsigned EntryBits   = ValueBits + CountBits + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lbp_pkg::pop_t        pop_i,
  output logic                 pop_ready_o,
  input  logic [EntryBits-1:0] pop_data_i,
  lbp_out_if.source            out_o
);

  localparam int unsigned HB = lbp_pkg::HELD_BITS;
  localparam int unsigned HC = lbp_pkg::HELD_CNT_BITS;
  localparam int unsigned BB = lbp_pkg::BYTE_BITS;
  localparam int unsigned TakeBits = HC + 1;

  // Queue word fields
  logic [ValueBits-1:0] e_value;
  logic [CountBits-1:0] e_count;
  logic                 e_fill;
  lbp_pkg::cmd_e        e_cmd;

  logic                 busy_q, busy_d;
  logic [ValueBits-1:0] sr_q, sr_d;
  logic [CountBits-1:0] rem_q, rem_d;
  logic                 fill_q, fill_d;
  logic [HB-1:0]        held_bits_q, held_bits_d;
  logic [HC-1:0]        held_cnt_q, held_cnt_d;
  logic                 ob_valid_q, ob_valid_d;
  logic [BB-1:0]        ob_byte_q, ob_byte_d;
  logic                 ob_last_q, ob_last_d;

  logic                 out_free;
  logic [CountBits:0]   total;
  logic [TakeBits-1:0]  take;
  logic [BB-1:0]        cur_byte;
  logic [ValueBits-1:0] sr_next;
  logic [CountBits-1:0] rem_next;
  logic [HB-1:0]        tail_mask;
  logic [HB-1:0]        rest_mask;
  logic                 pop;

  assign e_value = pop_data_i[ValueBits-1:0];
  assign e_count = pop_data_i[ValueBits +: CountBits];
  assign e_fill  = pop_data_i[ValueBits + CountBits];
  assign e_cmd   = lbp_pkg::cmd_e'(pop_data_i[EntryBits-1]);

  assign pop_ready_o = !busy_q;
  assign pop         = pop_i.valid & pop_i.ready;
  assign out_free    = !ob_valid_q || out_o.ready;

  // Byte assembly from held bits and the field shift register
  always_comb begin
    total     = {1'b0, rem_q} + (CountBits + 1)'(held_cnt_q);
    take      = TakeBits'(BB) - TakeBits'(held_cnt_q);
    cur_byte  = BB'({1'b0, held_bits_q}) | BB'(sr_q[BB-1:0] << held_cnt_q);
    sr_next   = (sr_q >> take) | (fill_q ? ~({ValueBits{1'b1}} >> take) : '0);
    rem_next  = rem_q - CountBits'(take);
    tail_mask = ~({HB{1'b1}} << rem_next[HC-1:0]);
    rest_mask = ~({HB{1'b1}} << rem_q[HC-1:0]);
  end

  // Load, step and retire one item; drop held bits on discard
  always_comb begin
    busy_d      = busy_q;
    sr_d        = sr_q;
    rem_d       = rem_q;
    fill_d      = fill_q;
    held_bits_d = held_bits_q;
    held_cnt_d  = held_cnt_q;
    ob_valid_d  = ob_valid_q & !out_o.ready;
    ob_byte_d   = ob_byte_q;
    ob_last_d   = ob_last_q;
    if (pop) begin
      if (e_cmd == lbp_pkg::CMD_DISCARD) begin
        held_bits_d = '0;
        held_cnt_d  = '0;
      end else begin
        busy_d = 1'b1;
        sr_d   = e_value;
        rem_d  = e_count;
        fill_d = e_fill;
      end
    end else if (busy_q) begin
      if (total >= (CountBits + 1)'(BB)) begin
        if (out_free) begin
          ob_valid_d  = 1'b1;
          ob_byte_d   = cur_byte;
          ob_last_d   = (rem_next < CountBits'(BB));
          sr_d        = sr_next;
          rem_d       = rem_next;
          held_bits_d = '0;
          held_cnt_d  = '0;
          if (rem_next < CountBits'(BB)) begin
            busy_d      = 1'b0;
            held_cnt_d  = rem_next[HC-1:0];
            held_bits_d = sr_next[HB-1:0] & tail_mask;
          end
        end
      end else begin
        busy_d      = 1'b0;
        held_cnt_d  = total[HC-1:0];
        held_bits_d = held_bits_q | HB'((sr_q[HB-1:0] & rest_mask) << held_cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      held_bits_q <= '0;
      held_cnt_q  <= '0;
      ob_valid_q  <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      held_bits_q <= held_bits_d;
      held_cnt_q  <= held_cnt_d;
      ob_valid_q  <= ob_valid_d;
    end
  end

  // Hold field and output payload
  always_ff @(posedge clk_i) begin
    sr_q      <= sr_d;
    rem_q     <= rem_d;
    fill_q    <= fill_d;
    ob_byte_q <= ob_byte_d;
    ob_last_q <= ob_last_d;
  end

  assign out_o.valid    = ob_valid_q;
  assign out_o.out_byte = ob_byte_q;
  assign out_o.last     = ob_last_q;

endmodule

// ----- hw/rtl/lsb_first_bit_packer_core.sv -----
// An accepted word is stored in the queue and then loaded into the back end's
// shift register; its first byte goes through the output byte register to out_o.
// The back end emits one byte per cycle while an append item is in progress and
// out_o is ready; it takes a new item from the queue only when idle, after the
// last one has retired. A discard clears the held bits. The back end's byte
// assembler sets the rate. Reset (rst_ni low, asynchronous) clears held bits,
// the queue and output valid.
module lsb_first_bit_packer_core #(
  parameter int unsigned ValueBits    = lbp_pkg::VALUE_BITS,
  parameter int unsigned MaxFieldBits = lbp_pkg::MAX_FIELD_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbp_in_if.sink     in_i,
  lbp_out_if.source  out_o
);

  localparam int unsigned CountBits = $clog2(MaxFieldBits + 1);
  localparam int unsigned EntryBits = ValueBits + CountBits + 2;

  logic                 push_valid;
  logic                 push_ready;
  logic [EntryBits-1:0] push_data;
  lbp_pkg::pop_t        pop;
  logic                 pop_ready;
  logic [EntryBits-1:0] pop_data;

  // Classify incoming words
  lbp_front #(
    .ValueBits    (ValueBits),
    .MaxFieldBits (MaxFieldBits)
  ) u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  // Decouple front from back
  lbp_queue #(
    .Width (EntryBits),
    .Depth (lbp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_o        (pop),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Emit packed bytes
  lbp_back #(
    .ValueBits    (ValueBits),
    .MaxFieldBits (MaxFieldBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule
